@@ src/wps_pkg.sv @@
// ----------------------------------------------------------------------------
// wps_pkg: shared types and constants of the ws2812 pixel serializer
// Register indexes, configuration bundle, queue entry and segment types.
// ----------------------------------------------------------------------------
`default_nettype none

package wps_pkg;

  // frame and pixel geometry
  localparam int MAX_LEDS       = 1024;
  localparam int POS_W          = $clog2(MAX_LEDS);
  localparam int LEN_W          = 11;
  localparam int BITS_PER_PIXEL = 24;
  localparam int BIT_IDX_W      = $clog2(BITS_PER_PIXEL);
  localparam int CHAN_W         = 8;
  localparam int TICK_W         = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CHAN_W-1:0] BRIGHT_BYPASS = 8'd255;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_LED_COUNT  = 3'd1,
    REG_ZERO_HIGH  = 3'd2,
    REG_ZERO_LOW   = 3'd3,
    REG_ONE_HIGH   = 3'd4,
    REG_ONE_LOW    = 3'd5,
    REG_LATCH      = 3'd6
  } cfg_reg_t;

  // live configuration seen by front and back
  typedef struct packed {
    logic [CHAN_W-1:0] brightness;
    logic [LEN_W-1:0]  led_count;
    logic [TICK_W-1:0] zero_high_ticks;
    logic [TICK_W-1:0] zero_low_ticks;
    logic [TICK_W-1:0] one_high_ticks;
    logic [TICK_W-1:0] one_low_ticks;
    logic [TICK_W-1:0] latch_ticks;
  } cfg_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [BITS_PER_PIXEL-1:0] word;
    logic                      frame_end;
  } pix_entry_t;

  // one line segment
  typedef struct packed {
    logic              line_level;
    logic [TICK_W-1:0] duration;
    logic              run_last;
  } seg_t;

  // zero tick count is sent as the shortest segment
  function automatic logic [TICK_W-1:0] ticks(input logic [TICK_W-1:0] t);
    ticks = (t == '0) ? TICK_W'(1) : t;
  endfunction

endpackage

`default_nettype wire

@@ src/ws2812_pixel_serializer.sv @@
// ----------------------------------------------------------------------------
// ws2812_pixel_serializer: ws2812 led serial encoder
// Turns RGB pixels into high/low line segments with tick durations.
// ----------------------------------------------------------------------------
// Input side is a queue: drive in_red/in_green/in_blue and raise in_push; a
// beat is taken at a clock edge with in_push high and in_full low. Result
// side is a queue too: while out_empty is low the oldest segment sits on
// out_line_level/out_duration/out_run_last and is taken when out_pop is high.
// Each pixel gives 48 segments (GRB, msb first, high then low per bit); the
// last pixel of a frame adds a low latch segment, 49 in all. out_run_last
// marks the final segment of each pixel.
// The first segment of a pixel passes the queue slot, word_r and seg_r registers.
// Throughput: one segment per cycle unless out_pop is held low, set by the
// back-end sequencer; a two-entry pixel queue lets the next pixel be taken
// while the current one is still going out.
// Configuration: cfg_valid/cfg_ready write channel, always ready; write only
// while the block is idle. Reset (rst_n low, synchronous) restores default
// registers, clears the frame position and empties both queues.
// When out_pop stays low, the segment holds, the back end stops, and once
// the pixel queue fills in_full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module ws2812_pixel_serializer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wps_pkg::CFG_DATA_W-1:0]    cfg_data,
  // pixel input
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic [wps_pkg::CHAN_W-1:0]        in_red,
  input  wire logic [wps_pkg::CHAN_W-1:0]        in_green,
  input  wire logic [wps_pkg::CHAN_W-1:0]        in_blue,
  // segment output
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output logic                                   out_line_level,
  output logic [wps_pkg::TICK_W-1:0]             out_duration,
  output logic                                   out_run_last
);

  wps_pkg::cfg_t       cfg_r;
  wps_pkg::pix_entry_t front_entry, q_entry;
  wps_pkg::seg_t       seg;
  logic                in_accept;
  logic                q_full, q_valid, q_pop;
  logic                seg_valid;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness      <= wps_pkg::CHAN_W'(255);
      cfg_r.led_count       <= wps_pkg::LEN_W'(1);
      cfg_r.zero_high_ticks <= wps_pkg::TICK_W'(10);
      cfg_r.zero_low_ticks  <= wps_pkg::TICK_W'(20);
      cfg_r.one_high_ticks  <= wps_pkg::TICK_W'(19);
      cfg_r.one_low_ticks   <= wps_pkg::TICK_W'(10);
      cfg_r.latch_ticks     <= wps_pkg::TICK_W'(1440);
    end else if (cfg_valid) begin
      case (cfg_index)
        wps_pkg::REG_BRIGHTNESS: cfg_r.brightness <= cfg_data[wps_pkg::CHAN_W-1:0];
        wps_pkg::REG_LED_COUNT:  cfg_r.led_count  <= cfg_data[wps_pkg::LEN_W-1:0];
        wps_pkg::REG_ZERO_HIGH:  cfg_r.zero_high_ticks <= cfg_data;
        wps_pkg::REG_ZERO_LOW:   cfg_r.zero_low_ticks  <= cfg_data;
        wps_pkg::REG_ONE_HIGH:   cfg_r.one_high_ticks  <= cfg_data;
        wps_pkg::REG_ONE_LOW:    cfg_r.one_low_ticks   <= cfg_data;
        wps_pkg::REG_LATCH:      cfg_r.latch_ticks     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  wps_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .accept(in_accept),
    .red   (in_red),
    .green (in_green),
    .blue  (in_blue),
    .entry (front_entry)
  );

  wps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_entry(front_entry),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_entry(q_entry)
  );

  wps_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .seg_valid(seg_valid),
    .seg      (seg),
    .seg_pop  (out_pop)
  );

  assign out_empty      = !seg_valid;
  assign out_line_level = seg.line_level;
  assign out_duration   = seg.duration;
  assign out_run_last   = seg.run_last;

endmodule

`default_nettype wire

@@ src/wps_queue.sv @@
// ----------------------------------------------------------------------------
// wps_queue: short pixel queue between front and back
// Flip-flop queue of classified pixels; both sides stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module wps_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire wps_pkg::pix_entry_t wr_entry,
  output logic                    full,
  input  wire logic               pop,
  output logic                    valid,
  output wps_pkg::pix_entry_t     rd_entry
);

  localparam int PTR_W = $clog2(wps_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(wps_pkg::QUEUE_DEPTH + 1);

  wps_pkg::pix_entry_t slot_r [wps_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(wps_pkg::QUEUE_DEPTH));
  assign valid    = (cnt_r != '0);
  assign rd_entry = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // pointer wrap at queue depth
  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(wps_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/wps_front.sv @@
// ----------------------------------------------------------------------------
// wps_front: pixel intake
// Scales channels, packs GRB word, tracks frame position, flags frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module wps_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire wps_pkg::cfg_t                 cfg,
  input  wire logic                          accept,
  input  wire logic [wps_pkg::CHAN_W-1:0]    red,
  input  wire logic [wps_pkg::CHAN_W-1:0]    green,
  input  wire logic [wps_pkg::CHAN_W-1:0]    blue,
  output wps_pkg::pix_entry_t                entry
);

  localparam int CW = wps_pkg::CHAN_W;
  localparam int LW = wps_pkg::LEN_W;

  logic [wps_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [LW-1:0]             frame_len;
  logic [LW-1:0]             pos_plus;
  logic [CW-1:0]             r_s, g_s, b_s;

  // channel scale, (c * brightness) >> 8 unless bypassed
  function automatic logic [CW-1:0] scale(input logic [CW-1:0] c,
                                          input logic [CW-1:0] br);
    logic [2*CW-1:0] prod;
    prod  = (2*CW)'(c) * (2*CW)'(br);
    scale = (br == wps_pkg::BRIGHT_BYPASS) ? c : prod[2*CW-1:CW];
  endfunction

  assign r_s = scale(red, cfg.brightness);
  assign g_s = scale(green, cfg.brightness);
  assign b_s = scale(blue, cfg.brightness);

  // frame length clamped to 1..MAX_LEDS
  always_comb begin
    if (cfg.led_count == '0) begin
      frame_len = LW'(1);
    end else if (cfg.led_count > LW'(wps_pkg::MAX_LEDS)) begin
      frame_len = LW'(wps_pkg::MAX_LEDS);
    end else begin
      frame_len = cfg.led_count;
    end
  end

  assign pos_plus        = LW'(pos_r) + LW'(1);
  assign entry.word      = {g_s, r_s, b_s};
  assign entry.frame_end = (pos_plus >= frame_len);

  // position advances per pixel, wraps at frame end
  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = entry.frame_end ? '0 : pos_plus[wps_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/wps_back.sv @@
// ----------------------------------------------------------------------------
// wps_back: segment generator
// Bit by bit per pixel word plus latch pulse, one segment per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wps_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire wps_pkg::cfg_t       cfg,
  input  wire logic                q_valid,
  input  wire wps_pkg::pix_entry_t q_entry,
  output logic                     q_pop,
  output logic                     seg_valid,
  output wps_pkg::seg_t            seg,
  input  wire logic                seg_pop
);

  localparam int NB = wps_pkg::BITS_PER_PIXEL;
  localparam int BW = wps_pkg::BIT_IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HIGH,
    ST_LOW,
    ST_LATCH
  } state_t;

  state_t                     state_r, state_nxt;
  logic [NB-1:0]              word_r, word_nxt;
  logic                       fe_r, fe_nxt;
  logic [BW-1:0]              bit_r, bit_nxt;
  logic                       seg_valid_r, seg_valid_nxt;
  wps_pkg::seg_t              seg_r, seg_nxt;
  logic                       adv;
  logic                       cur_one;
  logic                       last_bit;
  logic [wps_pkg::TICK_W-1:0] hi_dur, lo_dur;

  assign adv      = !seg_valid_r || seg_pop;
  assign cur_one  = word_r[NB-1];
  assign last_bit = (bit_r == BW'(NB - 1));
  assign hi_dur   = cur_one ? wps_pkg::ticks(cfg.one_high_ticks)
                            : wps_pkg::ticks(cfg.zero_high_ticks);
  assign lo_dur   = cur_one ? wps_pkg::ticks(cfg.one_low_ticks)
                            : wps_pkg::ticks(cfg.zero_low_ticks);

  assign seg_valid = seg_valid_r;
  assign seg       = seg_r;

  // sequencer: load, high, low per bit, optional latch
  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    fe_nxt        = fe_r;
    bit_nxt       = bit_r;
    seg_valid_nxt = seg_valid_r;
    seg_nxt       = seg_r;
    q_pop         = 1'b0;
    if (adv) begin
      seg_valid_nxt = 1'b0;
      case (state_r)
        ST_HIGH: begin
          seg_valid_nxt      = 1'b1;
          seg_nxt.line_level = 1'b1;
          seg_nxt.duration   = hi_dur;
          seg_nxt.run_last   = 1'b0;
          state_nxt          = ST_LOW;
        end
        ST_LOW: begin
          seg_valid_nxt      = 1'b1;
          seg_nxt.line_level = 1'b0;
          seg_nxt.duration   = lo_dur;
          seg_nxt.run_last   = last_bit && !fe_r;
          word_nxt           = {word_r[NB-2:0], 1'b0};
          bit_nxt            = bit_r + BW'(1);
          state_nxt          = ST_HIGH;
          if (last_bit) begin
            state_nxt = fe_r ? ST_LATCH : ST_IDLE;
          end
        end
        ST_LATCH: begin
          seg_valid_nxt      = 1'b1;
          seg_nxt.line_level = 1'b0;
          seg_nxt.duration   = wps_pkg::ticks(cfg.latch_ticks);
          seg_nxt.run_last   = 1'b1;
          state_nxt          = ST_IDLE;
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
      // pick up the next pixel without a gap
      if (state_nxt == ST_IDLE && q_valid) begin
        q_pop     = 1'b1;
        word_nxt  = q_entry.word;
        fe_nxt    = q_entry.frame_end;
        bit_nxt   = '0;
        state_nxt = ST_HIGH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seg_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_valid_r <= seg_valid_nxt;
    end
    word_r <= word_nxt;
    fe_r   <= fe_nxt;
    bit_r  <= bit_nxt;
    seg_r  <= seg_nxt;
  end

endmodule

`default_nettype wire

@@ src/wps_chk.sv @@
// ----------------------------------------------------------------------------
// wps_chk: port checker for the ws2812 pixel serializer
// Watches the segment channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wps_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_empty,
  input wire logic                          out_pop,
  input wire logic                          out_line_level,
  input wire logic [wps_pkg::TICK_W-1:0]    out_duration,
  input wire logic                          out_run_last
);

  // reset leaves nothing to deliver
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("segment visible right after reset");

  // a stalled segment holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_line_level)
      && $stable(out_duration) && $stable(out_run_last)))
    else $error("stalled segment changed");

  // a high segment never closes a pixel
  a_high_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_line_level) |-> !out_run_last)
    else $error("high segment flagged last");

  // durations are never zero
  a_dur_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_duration != '0))
    else $error("zero length segment");

  // a taken high segment is followed at once by its low half
  a_high_then_low: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && out_line_level) |=> (!out_empty && !out_line_level))
    else $error("high segment not followed by low");

endmodule

bind ws2812_pixel_serializer wps_chk u_wps_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_line_level(out_line_level),
  .out_duration  (out_duration),
  .out_run_last  (out_run_last)
);

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ws2812 pixel serializer
// Pixels are pushed from a pending queue by a clocked driver with random gaps.
// A clocked monitor predicts the GRB bit segments (and the latch segment that
// ends a frame) for each accepted pixel, pops results with random stalls and
// checks every segment field against the oldest prediction. Registers are
// rewritten between phases only once all predicted segments have arrived.
// ----------------------------------------------------------------------------

module tb;

  // unused register slot, writes to it must be ignored
  localparam logic [wps_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [wps_pkg::CHAN_W-1:0] red;
    logic [wps_pkg::CHAN_W-1:0] green;
    logic [wps_pkg::CHAN_W-1:0] blue;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [wps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic                       in_push = 1'b0;
  logic                       in_full;
  logic [wps_pkg::CHAN_W-1:0] in_red = '0;
  logic [wps_pkg::CHAN_W-1:0] in_green = '0;
  logic [wps_pkg::CHAN_W-1:0] in_blue = '0;

  logic                       out_empty;
  logic                       out_pop = 1'b0;
  logic                       out_line_level;
  logic [wps_pkg::TICK_W-1:0] out_duration;
  logic                       out_run_last;

  // bench state
  pixel_t        pixel_queue[$];
  wps_pkg::seg_t seg_expect[$];
  wps_pkg::cfg_t cfg_shadow = '{brightness: 8'd255, led_count: 11'd1,
                                zero_high_ticks: 16'd10, zero_low_ticks: 16'd20,
                                one_high_ticks: 16'd19, one_low_ticks: 16'd10,
                                latch_ticks: 16'd1440};
  logic [wps_pkg::POS_W-1:0] frame_pos = '0;
  logic pix_taken = 1'b0;
  logic calm = 1'b0;
  int   gap_left = 0;
  int   pop_hold = 0;
  int   err_count = 0;
  int   seg_count = 0;

  ws2812_pixel_serializer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_line_level (out_line_level),
    .out_duration   (out_duration),
    .out_run_last   (out_run_last)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    if (err_count < 100)
      $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(20, 120);
  endfunction

  function automatic logic [wps_pkg::CHAN_W-1:0] scale_chan(
      input logic [wps_pkg::CHAN_W-1:0] c);
    logic [2*wps_pkg::CHAN_W-1:0] prod;
    if (cfg_shadow.brightness == 8'd255)
      return c;
    prod = (2*wps_pkg::CHAN_W)'(c) * (2*wps_pkg::CHAN_W)'(cfg_shadow.brightness);
    return prod[2*wps_pkg::CHAN_W-1:wps_pkg::CHAN_W];
  endfunction

  // a zero tick count goes out as a one tick segment
  function automatic logic [wps_pkg::TICK_W-1:0] nonzero_ticks(
      input logic [wps_pkg::TICK_W-1:0] t);
    return (t == '0) ? wps_pkg::TICK_W'(1) : t;
  endfunction

  // predict the segments of one pixel and advance the frame position
  function automatic void encode_pixel(input pixel_t px);
    logic [wps_pkg::BITS_PER_PIXEL-1:0] word;
    logic bit_val;
    logic frame_end;
    int flen;
    wps_pkg::seg_t s;
    word = {scale_chan(px.green), scale_chan(px.red), scale_chan(px.blue)};
    flen = int'(cfg_shadow.led_count);
    if (flen == 0)
      flen = 1;
    if (flen > wps_pkg::MAX_LEDS)
      flen = wps_pkg::MAX_LEDS;
    frame_end = (int'(frame_pos) + 1) >= flen;
    for (int i = wps_pkg::BITS_PER_PIXEL - 1; i >= 0; i--) begin
      bit_val = word[i];
      s.line_level = 1'b1;
      s.duration = nonzero_ticks(bit_val ? cfg_shadow.one_high_ticks
                                         : cfg_shadow.zero_high_ticks);
      s.run_last = 1'b0;
      seg_expect.push_back(s);
      s.line_level = 1'b0;
      s.duration = nonzero_ticks(bit_val ? cfg_shadow.one_low_ticks
                                         : cfg_shadow.zero_low_ticks);
      s.run_last = (i == 0) && !frame_end;
      seg_expect.push_back(s);
    end
    if (frame_end) begin
      s.line_level = 1'b0;
      s.duration = nonzero_ticks(cfg_shadow.latch_ticks);
      s.run_last = 1'b1;
      seg_expect.push_back(s);
      frame_pos = '0;
    end else begin
      frame_pos = frame_pos + wps_pkg::POS_W'(1);
    end
  endfunction

  // monitor: register writes, accepted pixels and popped segments
  always @(posedge clk) begin
    wps_pkg::seg_t want;
    pix_taken <= in_push && !in_full;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wps_pkg::REG_BRIGHTNESS:
            cfg_shadow.brightness = cfg_data[wps_pkg::CHAN_W-1:0];
          wps_pkg::REG_LED_COUNT:
            cfg_shadow.led_count = cfg_data[wps_pkg::LEN_W-1:0];
          wps_pkg::REG_ZERO_HIGH: cfg_shadow.zero_high_ticks = cfg_data;
          wps_pkg::REG_ZERO_LOW:  cfg_shadow.zero_low_ticks = cfg_data;
          wps_pkg::REG_ONE_HIGH:  cfg_shadow.one_high_ticks = cfg_data;
          wps_pkg::REG_ONE_LOW:   cfg_shadow.one_low_ticks = cfg_data;
          wps_pkg::REG_LATCH:     cfg_shadow.latch_ticks = cfg_data;
          default: ;
        endcase
      end
      if (in_push && !in_full)
        encode_pixel('{red: in_red, green: in_green, blue: in_blue});
      if (out_pop && !out_empty) begin
        if (seg_expect.size() == 0) begin
          flag_error($sformatf("segment %0d not expected: level %0b dur %0d last %0b",
                               seg_count, out_line_level, out_duration, out_run_last));
        end else begin
          want = seg_expect.pop_front();
          if (out_line_level !== want.line_level)
            flag_error($sformatf("segment %0d line_level %0b, want %0b",
                                 seg_count, out_line_level, want.line_level));
          if (out_duration !== want.duration)
            flag_error($sformatf("segment %0d duration %0d, want %0d",
                                 seg_count, out_duration, want.duration));
          if (out_run_last !== want.run_last)
            flag_error($sformatf("segment %0d run_last %0b, want %0b",
                                 seg_count, out_run_last, want.run_last));
        end
        seg_count++;
      end
    end
  end

  // pixel driver: one beat per pending entry, random gaps between beats
  always @(negedge clk) begin
    pixel_t px;
    if (rst_n) begin
      if (in_push && pix_taken)
        gap_left = pick_gap();
      else if (!in_push && gap_left != 0)
        gap_left--;
      if (!in_push || pix_taken) begin
        if (gap_left == 0 && pixel_queue.size() != 0) begin
          px = pixel_queue.pop_front();
          in_push <= 1'b1;
          in_red <= px.red;
          in_green <= px.green;
          in_blue <= px.blue;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // segment consumer: random stalls, none in calm stretches
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (calm) begin
      out_pop <= 1'b1;
    end else if (pop_hold != 0) begin
      pop_hold <= pop_hold - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      if ($urandom_range(0, 3) == 0)
        pop_hold <= pick_gap();
    end
  end

  function automatic void queue_pixel(input logic [wps_pkg::CHAN_W-1:0] r,
                                      input logic [wps_pkg::CHAN_W-1:0] g,
                                      input logic [wps_pkg::CHAN_W-1:0] b);
    pixel_queue.push_back('{red: r, green: g, blue: b});
  endfunction

  function automatic logic [wps_pkg::CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return wps_pkg::CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [wps_pkg::TICK_W-1:0] rand_ticks();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return wps_pkg::TICK_W'(1);
      2: return '1;
      default: return wps_pkg::TICK_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // random register value; upper data bits beyond a register's width vary too
  function automatic logic [wps_pkg::CFG_DATA_W-1:0] rand_reg_value(
      input logic [wps_pkg::CFG_IDX_W-1:0] idx);
    logic [wps_pkg::CFG_DATA_W-1:0] v;
    case (idx)
      wps_pkg::REG_BRIGHTNESS: begin
        case ($urandom_range(0, 4))
          0: v = 16'd255;
          1: v = 16'd0;
          default: v = wps_pkg::CFG_DATA_W'($urandom_range(0, 65535));
        endcase
      end
      wps_pkg::REG_LED_COUNT: begin
        v = wps_pkg::CFG_DATA_W'($urandom_range(0, 31)) << wps_pkg::LEN_W;
        case ($urandom_range(0, 9))
          0: v[wps_pkg::LEN_W-1:0] = '0;
          1: v[wps_pkg::LEN_W-1:0] = wps_pkg::LEN_W'(wps_pkg::MAX_LEDS);
          2: v[wps_pkg::LEN_W-1:0] =
               wps_pkg::LEN_W'($urandom_range(wps_pkg::MAX_LEDS + 1, 2047));
          3, 4, 5: v[wps_pkg::LEN_W-1:0] = wps_pkg::LEN_W'($urandom_range(1, 4));
          default: v[wps_pkg::LEN_W-1:0] = wps_pkg::LEN_W'($urandom_range(5, 40));
        endcase
      end
      default: v = rand_ticks();
    endcase
    return v;
  endfunction

  task automatic cfg_write(input logic [wps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wps_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // block is idle once every pending pixel went in and every segment came out
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || in_push || seg_expect.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_ticks(input logic [wps_pkg::TICK_W-1:0] val);
    cfg_write(wps_pkg::REG_ZERO_HIGH, val);
    cfg_write(wps_pkg::REG_ZERO_LOW, val);
    cfg_write(wps_pkg::REG_ONE_HIGH, val);
    cfg_write(wps_pkg::REG_ONE_LOW, val);
    cfg_write(wps_pkg::REG_LATCH, val);
  endtask

  // run time limit
  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults, one pixel per frame
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'hA5, 8'h3C, 8'h81);
    wait_drained();

    // brightness scaling at its extremes and midpoint
    cfg_write(wps_pkg::REG_BRIGHTNESS, 16'd0);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    wait_drained();
    cfg_write(wps_pkg::REG_BRIGHTNESS, 16'd128);
    queue_pixel(8'hFF, 8'h80, 8'h01);
    wait_drained();
    cfg_write(wps_pkg::REG_BRIGHTNESS, 16'd1);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    wait_drained();
    cfg_write(wps_pkg::REG_BRIGHTNESS, 16'd255);

    // zero tick counts go out as one tick, then the largest counts
    write_ticks('0);
    queue_pixel(8'hF0, 8'h0F, 8'h33);
    wait_drained();
    write_ticks('1);
    queue_pixel(8'h5A, 8'hC3, 8'h7E);
    wait_drained();

    // zero frame length acts as one
    cfg_write(wps_pkg::REG_ZERO_HIGH, 16'd10);
    cfg_write(wps_pkg::REG_ZERO_LOW, 16'd20);
    cfg_write(wps_pkg::REG_ONE_HIGH, 16'd19);
    cfg_write(wps_pkg::REG_ONE_LOW, 16'd10);
    cfg_write(wps_pkg::REG_LATCH, 16'd1440);
    cfg_write(wps_pkg::REG_LED_COUNT, 16'd0);
    queue_pixel(8'h12, 8'h34, 8'h56);
    queue_pixel(8'h9A, 8'hBC, 8'hDE);
    wait_drained();

    // frame length lowered below the current position mid-frame
    cfg_write(wps_pkg::REG_LED_COUNT, 16'd5);
    repeat (3) queue_pixel(rand_chan(), rand_chan(), rand_chan());
    wait_drained();
    cfg_write(wps_pkg::REG_LED_COUNT, 16'd2);
    repeat (2) queue_pixel(rand_chan(), rand_chan(), rand_chan());
    wait_drained();

    // write to the spare slot must change nothing
    cfg_write(REG_SPARE, 16'h0000);
    queue_pixel(8'hC0, 8'h03, 8'h18);
    wait_drained();

    // oversized frame length saturates: a few pixels into the long frame
    calm = 1'b1;
    cfg_write(wps_pkg::REG_LED_COUNT, 16'hFFFF);
    repeat (4) queue_pixel(rand_chan(), rand_chan(), rand_chan());
    wait_drained();

    // random phases, all registers rewritten between them
    for (int phase = 0; phase < 6; phase++) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k <= int'(REG_SPARE); k++)
        cfg_write(wps_pkg::CFG_IDX_W'(k), rand_reg_value(wps_pkg::CFG_IDX_W'(k)));
      n = $urandom_range(22, 30);
      repeat (n) queue_pixel(rand_chan(), rand_chan(), rand_chan());
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (seg_expect.size() != 0)
      flag_error($sformatf("%0d segments never arrived", seg_expect.size()));
    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
